// ===== src/crcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, constants and CRC helper for the CRC-8 frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  // Sync bytes that open a frame
  localparam logic [7:0] SYNC_MAIN  = 8'h5A;
  localparam logic [7:0] SYNC_ALT_A = 8'hB4;
  localparam logic [7:0] SYNC_ALT_B = 8'h2D;

  // CRC-8 generator, MSB first, init zero
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Position of the CRC byte in a 9-byte frame
  localparam logic [3:0] FRAME_LAST = 4'd8;

  // Stick center code and its 16-bit image
  localparam logic [7:0]  STICK_MID        = 8'h80;
  localparam logic [15:0] STICK_MID_SCALED = 16'h8000;

  // Saturation value of the millisecond counter
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  // Register reset values
  localparam logic [7:0]  RESET_ID_MASK = 8'd3;
  localparam logic [15:0] RESET_TIMEOUT = 16'd250;

  // Default depth of the internal queues
  localparam int QUEUE_DEPTH = 2;

  // Register map (word index)
  typedef enum logic [0:0] {
    REG_ID_MASK = 1'b0,
    REG_TIMEOUT = 1'b1
  } cfg_reg_t;

  // Input request
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_t;

  // Result
  typedef struct packed {
    logic        frame_done;
    logic        frame_ok;
    logic [7:0]  slot_id;
    logic [7:0]  last_flags;
    logic [15:0] last_buttons;
    logic [15:0] left_x;
    logic [15:0] left_y;
    logic [15:0] right_x;
    logic [15:0] right_y;
    logic        have_packet;
    logic        fresh;
    logic [7:0]  good_count;
  } out_t;

  // Classified request from front to back; payload is frame bytes 1..7, byte 1 low
  typedef struct packed {
    logic        tick;
    logic        done;
    logic        ok;
    logic [55:0] payload;
  } req_t;

  // One CRC byte update: eight shift steps of the register (caller XORs data in)
  function automatic logic [7:0] crc8_step(input logic [7:0] c_in);
    logic [7:0] c;
    c = c_in;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Scale a stick byte to 16 bits: v*257, center maps to 0x8000
  function automatic logic [15:0] scale_stick(input logic [7:0] v);
    return (v == STICK_MID) ? STICK_MID_SCALED : {v, v};
  endfunction

endpackage

// ===== src/crcfr_queue.sv =====
// ----------------------------------------------------------------------------
// crcfr_queue
// Small register FIFO with full/empty flags and push-while-pop support.
// ----------------------------------------------------------------------------
module crcfr_queue #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [Width-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [Width-1:0] rd_data,
  output logic             empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] store [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CntFull);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/crcfr_front.sv =====
// ----------------------------------------------------------------------------
// crcfr_front
// Sync hunt, frame assembly and running CRCs (direct and one-bit shifted).
// ----------------------------------------------------------------------------
module crcfr_front
  import crcfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  in_t  item,
  output req_t req
);

  logic [3:0] idx;
  logic [7:0] frame_store [8];
  logic [7:0] crc_d;
  logic [7:0] crc_s;

  logic [7:0] b;
  logic       is_sync;
  logic [3:0] idx_prev;
  logic [7:0] prev_byte;
  logic [7:0] shifted_byte;
  logic [7:0] crc_s_in;
  logic [7:0] crc_s_upd;
  logic [7:0] crc_d_upd;
  logic [7:0] use0;
  logic       ok_d;
  logic       ok_s;
  logic [55:0] pay_direct;
  logic [55:0] pay_shift;

  assign b       = item.rx_byte;
  assign is_sync = (b == SYNC_MAIN) || (b == SYNC_ALT_A) || (b == SYNC_ALT_B);

  // Previous byte of the frame feeds the shifted stream
  assign idx_prev     = idx - 4'd1;
  assign prev_byte    = frame_store[idx_prev[2:0]];
  assign shifted_byte = {prev_byte[6:0], b[7]};
  assign crc_s_in     = (idx == 4'd1) ? 8'h00 : crc_s;
  assign crc_s_upd    = crc8_step(crc_s_in ^ shifted_byte);
  assign crc_d_upd    = crc8_step(((idx == 4'd0) ? 8'h00 : crc_d) ^ b);

  // Frame checks on the last byte
  assign use0 = {frame_store[0][6:0], frame_store[1][7]};
  assign ok_d = (frame_store[0] == SYNC_MAIN) && (crc_d == b);
  assign ok_s = (use0 == SYNC_MAIN) && (crc_s_upd == {b[6:0], 1'b0});

  // Payload candidates, byte 1 in the low lane
  always_comb begin
    for (int i = 1; i < 8; i++) begin
      pay_direct[8*(i-1) +: 8] = frame_store[i];
      if (i < 7) begin
        pay_shift[8*(i-1) +: 8] = {frame_store[i][6:0], frame_store[i+1][7]};
      end else begin
        pay_shift[8*(i-1) +: 8] = {frame_store[i][6:0], b[7]};
      end
    end
  end

  // Classified request
  always_comb begin
    req.tick    = item.func;
    req.done    = !item.func && (idx == FRAME_LAST);
    req.ok      = req.done && (ok_d || ok_s);
    req.payload = ok_d ? pay_direct : pay_shift;
  end

  // Frame bytes
  always_ff @(posedge clk) begin
    if (accept && !item.func && idx != FRAME_LAST && (idx != 4'd0 || is_sync)) begin
      frame_store[idx[2:0]] <= b;
    end
  end

  // Running CRCs; the direct CRC also updates on bytes seen while hunting
  always_ff @(posedge clk) begin
    if (accept && !item.func) begin
      if (idx != FRAME_LAST) begin
        crc_d <= crc_d_upd;
      end
      if (idx != 4'd0) begin
        crc_s <= crc_s_upd;
      end
    end
  end

  // Byte position; zero means hunting
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept && !item.func) begin
      if (idx == 4'd0) begin
        if (is_sync) begin
          idx <= 4'd1;
        end
      end else if (idx == FRAME_LAST) begin
        idx <= 4'd0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

endmodule

// ===== src/crcfr_back.sv =====
// ----------------------------------------------------------------------------
// crcfr_back
// Applies classified requests to the receiver state and forms results.
// ----------------------------------------------------------------------------
module crcfr_back
  import crcfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  req_t        req,
  input  logic [7:0]  id_mask,
  input  logic [15:0] timeout,
  output out_t        res
);

  logic [55:0] stored_payload, stored_payload_next;
  logic [7:0]  learned_slot, learned_slot_next;
  logic        seen_good, seen_good_next;
  logic [7:0]  frame_counter, frame_counter_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;

  // Next state for the request at the queue head
  always_comb begin
    stored_payload_next = stored_payload;
    learned_slot_next   = learned_slot;
    seen_good_next      = seen_good;
    frame_counter_next  = frame_counter;
    elapsed_ms_next     = elapsed_ms;
    if (req.tick) begin
      if (elapsed_ms != ELAPSED_MAX) begin
        elapsed_ms_next = elapsed_ms + 16'd1;
      end
    end else if (req.ok) begin
      stored_payload_next = req.payload;
      learned_slot_next   = req.payload[7:0] & id_mask;
      seen_good_next      = 1'b1;
      frame_counter_next  = frame_counter + 8'd1;
      elapsed_ms_next     = '0;
    end
  end

  // Result reflects the state after the update
  always_comb begin
    res.frame_done   = req.done;
    res.frame_ok     = req.ok;
    res.slot_id      = learned_slot_next;
    res.last_flags   = stored_payload_next[7:0];
    res.last_buttons = stored_payload_next[23:8];
    res.left_x       = scale_stick(stored_payload_next[31:24]);
    res.left_y       = scale_stick(stored_payload_next[39:32]);
    res.right_x      = scale_stick(stored_payload_next[47:40]);
    res.right_y      = scale_stick(stored_payload_next[55:48]);
    res.have_packet  = seen_good_next;
    res.fresh        = (elapsed_ms_next <= timeout);
    res.good_count   = frame_counter_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_payload <= '0;
      learned_slot   <= '0;
      seen_good      <= 1'b0;
      frame_counter  <= '0;
      elapsed_ms     <= '0;
    end else if (fire) begin
      stored_payload <= stored_payload_next;
      learned_slot   <= learned_slot_next;
      seen_good      <= seen_good_next;
      frame_counter  <= frame_counter_next;
      elapsed_ms     <= elapsed_ms_next;
    end
  end

endmodule

// ===== src/crc8_frame_receiver_bit_slip_unit.sv =====
// ----------------------------------------------------------------------------
// crc8_frame_receiver_bit_slip_unit
// CRC-8 checked 9-byte frame receiver with one-bit slip recovery.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through push/full: a received SPI byte (func = 0) or a
//   one-millisecond tick (func = 1). Every request yields exactly one result,
//   in order, read through empty/pop; the result at the head stays on the
//   result port while empty is low.
//   The front stage hunts for sync, stores the frame and keeps two running
//   CRC-8 values (as received and shifted left one bit), so the check at the
//   ninth byte is a compare. A request queue feeds the back stage, which
//   updates the stored controller state; a result queue holds its output.
//   Path: an accepted request is registered in the request queue, and its
//   result in the result queue. Throughput: one request per cycle while
//   results are popped, limited by the single back-stage update per cycle.
//   Reset clears the hunt state, all learned state and both queues; registers
//   return to mask 3 and timeout 250 ms. When the receiver does not pop, the
//   result queue fills, then the request queue, and full rises.
//   Registers: byte address 0 id mask (8 bits), 4 timeout in ms (16 bits).
// ----------------------------------------------------------------------------
module crc8_frame_receiver_bit_slip_unit
  import crcfr_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_t         item,
  output logic        empty,
  input  logic        pop,
  output out_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        accept;
  req_t        req_in;
  req_t        req_head;
  logic        req_empty;
  logic        res_full;
  logic        fire;
  out_t        res_in;
  logic [7:0]  id_mask;
  logic [15:0] timeout;
  cfg_reg_t    reg_sel;

  assign accept = push && !full;
  assign fire   = !req_empty && !res_full;

  // Register port
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      id_mask <= RESET_ID_MASK;
      timeout <= RESET_TIMEOUT;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_ID_MASK: id_mask <= pwdata[7:0];
        REG_TIMEOUT: timeout <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ID_MASK: prdata = {24'd0, id_mask};
      REG_TIMEOUT: prdata = {16'd0, timeout};
      default:     prdata = '0;
    endcase
  end

  // Front: hunt, assemble, check
  crcfr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .req    (req_in)
  );

  // Request queue between front and back
  crcfr_queue #(
    .Width ($bits(req_t)),
    .Depth (QueueDepth)
  ) u_req_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (req_in),
    .full    (full),
    .rd_en   (fire),
    .rd_data (req_head),
    .empty   (req_empty)
  );

  // Back: state update and result
  crcfr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .req     (req_head),
    .id_mask (id_mask),
    .timeout (timeout),
    .res     (res_in)
  );

  // Result queue
  crcfr_queue #(
    .Width ($bits(out_t)),
    .Depth (QueueDepth)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fire),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

// ===== src/crcfr_checker.sv =====
// ----------------------------------------------------------------------------
// crcfr_checker
// Port-level checks for the CRC-8 frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module crcfr_checker
  import crcfr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input out_t result
);

  // Nothing to read right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // A result not taken stays, unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result dropped or changed");

  // A good frame is always a completed frame
  a_ok_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.frame_ok) |-> result.frame_done)
    else $error("frame_ok without frame_done");

  // A good frame restarts the timer and marks a packet seen
  a_ok_fresh: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.frame_ok) |-> (result.fresh && result.have_packet))
    else $error("good frame not fresh or not recorded");

endmodule

bind crc8_frame_receiver_bit_slip_unit crcfr_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
